// ----- design/oxd_pkg.sv -----
// Shared constants for the omni X drive wheel speed pipeline.
// No dependencies; used by oxd_prep, oxd_cell, oxd_out and the top level.
`default_nettype none

package oxd_pkg;

  // Fraction bits carried through the rotator beyond Q.12.
  localparam int unsigned EXTRA_FRAC = 16;
  localparam int unsigned CORDIC_STEPS = 24;
  // Angle word of the rotator: 2^32 per turn, signed.
  localparam int unsigned ZW = 32;
  // CORDIC gain compensation, Q30.
  localparam int unsigned GAIN_BITS = 31;
  localparam logic signed [GAIN_BITS-1:0] GAIN_Q30 = 31'sd652032874;

  // Quadrant codes removed ahead of the rotator.
  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  // Arctangent of 2^-i in 2^32-per-turn units.
  localparam logic signed [ZW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

`default_nettype wire

// ----- design/oxd_prep.sv -----
// Front end: gain multiply, angle reduction and quadrant swap, two stages.
// Depends on oxd_pkg.
`default_nettype none

module oxd_prep #(
  parameter int unsigned VELOCITY_BITS = 16,
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned W = 35
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [VELOCITY_BITS-1:0] vel_x_i,
  input  wire logic signed [VELOCITY_BITS-1:0] vel_y_i,
  input  wire logic signed [VELOCITY_BITS-1:0] rate_i,
  input  wire logic [ANGLE_BITS-1:0]         heading_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic signed [W-1:0]                x_o,
  output logic signed [W-1:0]                y_o,
  output logic signed [oxd_pkg::ZW-1:0]      z_o,
  output logic signed [VELOCITY_BITS-1:0]    rate_o
);
  import oxd_pkg::*;

  localparam int unsigned PW = VELOCITY_BITS + GAIN_BITS;
  localparam int unsigned SHIFT = 30 - EXTRA_FRAC;
  localparam int unsigned SW = PW - SHIFT;
  localparam int unsigned PAD = W - SW;
  localparam logic [ANGLE_BITS-1:0] EIGHTH = {3'b001, {(ANGLE_BITS-3){1'b0}}};

  logic signed [PW-1:0] prod_x, prod_y;
  logic [ANGLE_BITS-1:0] theta, theta_rnd, resid;
  logic [1:0] quad;

  logic v1_q, rdy1;
  logic signed [W-1:0] x1_q, y1_q;
  logic signed [ZW-1:0] z1_q;
  logic [1:0] quad_q;
  logic signed [VELOCITY_BITS-1:0] rate1_q;

  logic v2_q, rdy2;
  logic signed [W-1:0] x2_d, y2_d;

  assign prod_x = vel_x_i * GAIN_Q30;
  assign prod_y = vel_y_i * GAIN_Q30;

  // theta = eighth - heading; nearest quadrant leaves a residue within +-1/8 turn
  assign theta     = EIGHTH - heading_i;
  assign theta_rnd = theta + EIGHTH;
  assign quad      = theta_rnd[ANGLE_BITS-1 -: 2];
  assign resid     = theta - {quad, {(ANGLE_BITS-2){1'b0}}};

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      x1_q    <= {{PAD{prod_x[PW-1]}}, prod_x[PW-1:SHIFT]};
      y1_q    <= {{PAD{prod_y[PW-1]}}, prod_y[PW-1:SHIFT]};
      z1_q    <= {resid, {(ZW-ANGLE_BITS){1'b0}}};
      quad_q  <= quad;
      rate1_q <= rate_i;
    end
  end

  always_comb begin
    unique case (quad_q)
      QUAD_0:   begin x2_d = x1_q;  y2_d = y1_q;  end
      QUAD_90:  begin x2_d = -y1_q; y2_d = x1_q;  end
      QUAD_180: begin x2_d = -x1_q; y2_d = -y1_q; end
      QUAD_270: begin x2_d = y1_q;  y2_d = -x1_q; end
      default:  begin x2_d = x1_q;  y2_d = y1_q;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      x_o    <= x2_d;
      y_o    <= y2_d;
      z_o    <= z1_q;
      rate_o <= rate1_q;
    end
  end

  assign valid_o = v2_q;

endmodule

`default_nettype wire

// ----- design/oxd_cell.sv -----
// One CORDIC rotation step with its own pipeline register.
// Depends on oxd_pkg.
`default_nettype none

module oxd_cell #(
  parameter int unsigned VELOCITY_BITS = 16,
  parameter int unsigned W = 35,
  parameter int unsigned STEP = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [W-1:0]           x_i,
  input  wire logic signed [W-1:0]           y_i,
  input  wire logic signed [oxd_pkg::ZW-1:0] z_i,
  input  wire logic signed [VELOCITY_BITS-1:0] rate_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic signed [W-1:0]                x_o,
  output logic signed [W-1:0]                y_o,
  output logic signed [oxd_pkg::ZW-1:0]      z_o,
  output logic signed [VELOCITY_BITS-1:0]    rate_o
);
  import oxd_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ATAN_TURN[STEP];

  logic valid_q;
  logic signed [W-1:0] dx, dy, x_d, y_d;
  logic signed [ZW-1:0] z_d;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  // rotate toward zero residual angle
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ANGLE;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ANGLE;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      rate_o <= rate_i;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- design/oxd_out.sv -----
// Back end: round the rotated vector to Q.12, form the four wheel sums,
// hold them in the output register. Depends on oxd_pkg.
`default_nettype none

module oxd_out #(
  parameter int unsigned VELOCITY_BITS = 16,
  parameter int unsigned W = 35
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic signed [W-1:0]             x_i,
  input  wire logic signed [W-1:0]             y_i,
  input  wire logic signed [VELOCITY_BITS-1:0] rate_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output logic signed [VELOCITY_BITS+1:0]      lf_o,
  output logic signed [VELOCITY_BITS+1:0]      rf_o,
  output logic signed [VELOCITY_BITS+1:0]      lr_o,
  output logic signed [VELOCITY_BITS+1:0]      rr_o
);
  import oxd_pkg::*;

  localparam int unsigned OW = VELOCITY_BITS + 2;
  localparam logic signed [W-1:0] HALF = W'(1) <<< (EXTRA_FRAC - 1);

  logic valid_q;
  logic signed [W-1:0] x_rnd, y_rnd, r0_full, r1_full;
  logic signed [OW-1:0] r0, r1, rate_ext;

  assign x_rnd   = x_i + HALF;
  assign y_rnd   = y_i + HALF;
  assign r0_full = x_rnd >>> EXTRA_FRAC;
  assign r1_full = y_rnd >>> EXTRA_FRAC;
  assign r0      = r0_full[OW-1:0];
  assign r1      = r1_full[OW-1:0];
  assign rate_ext = {{2{rate_i[VELOCITY_BITS-1]}}, rate_i};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lf_o <= rate_ext + r0;
      rf_o <= rate_ext - r1;
      lr_o <= rate_ext + r1;
      rr_o <= rate_ext - r0;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- design/omni_x_drive_wheel_speeds_unit.sv -----
// Top level of the omni X drive wheel speed unit: front end, a row of
// CORDIC cells and the output stage. Depends on oxd_pkg, oxd_prep,
// oxd_cell and oxd_out.
//
//   channel  dir  tdata fields, lowest bit first
//   s_axis   in   velocity_x, velocity_y, rotation_rate, heading_offset
//   m_axis   out  wheel speeds front-left, front-right, back-left,
//                 back-right
//
// One request per cycle while m_axis_tready is held high; two front end
// stages (gain multiply, quadrant swap), 24 CORDIC cells, one output register.
// Every stage has its own valid bit, so a bubble is filled even while the
// output is stalled; back pressure ripples back through the cell row.
// Reset clears the valid bits only.
`default_nettype none

module omni_x_drive_wheel_speeds_unit #(
  parameter int unsigned VELOCITY_BITS = 16,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // velocity_x, velocity_y, rotation_rate, heading_offset, zero pad
  input  wire logic [((3*VELOCITY_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // wheel speeds front-left, front-right, back-left, back-right, zero pad
  output logic [((4*(VELOCITY_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  import oxd_pkg::*;

  localparam int unsigned VB = VELOCITY_BITS;
  localparam int unsigned OW = VB + 2;
  localparam int unsigned W = VB + EXTRA_FRAC + 3;
  localparam int unsigned OUT_BITS = 4 * OW;
  localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8;

  logic signed [VB-1:0] vel_x, vel_y, rate_in;
  logic [ANGLE_BITS-1:0] heading;

  logic                  c_valid [CORDIC_STEPS+1];
  logic                  c_ready [CORDIC_STEPS+1];
  logic signed [W-1:0]   c_x     [CORDIC_STEPS+1];
  logic signed [W-1:0]   c_y     [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  c_z     [CORDIC_STEPS+1];
  logic signed [VB-1:0]  c_rate  [CORDIC_STEPS+1];

  logic signed [OW-1:0] fl, fr, bl, br;

  assign vel_x   = s_axis_tdata[VB-1:0];
  assign vel_y   = s_axis_tdata[2*VB-1:VB];
  assign rate_in = s_axis_tdata[3*VB-1:2*VB];
  assign heading = s_axis_tdata[3*VB+ANGLE_BITS-1:3*VB];

  oxd_prep #(
    .VELOCITY_BITS(VB),
    .ANGLE_BITS   (ANGLE_BITS),
    .W            (W)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .vel_x_i  (vel_x),
    .vel_y_i  (vel_y),
    .rate_i   (rate_in),
    .heading_i(heading),
    .valid_o  (c_valid[0]),
    .ready_i  (c_ready[0]),
    .x_o      (c_x[0]),
    .y_o      (c_y[0]),
    .z_o      (c_z[0]),
    .rate_o   (c_rate[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    oxd_cell #(
      .VELOCITY_BITS(VB),
      .W            (W),
      .STEP         (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(c_valid[i]),
      .ready_o(c_ready[i]),
      .x_i    (c_x[i]),
      .y_i    (c_y[i]),
      .z_i    (c_z[i]),
      .rate_i (c_rate[i]),
      .valid_o(c_valid[i+1]),
      .ready_i(c_ready[i+1]),
      .x_o    (c_x[i+1]),
      .y_o    (c_y[i+1]),
      .z_o    (c_z[i+1]),
      .rate_o (c_rate[i+1])
    );
  end

  oxd_out #(
    .VELOCITY_BITS(VB),
    .W            (W)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(c_valid[CORDIC_STEPS]),
    .ready_o(c_ready[CORDIC_STEPS]),
    .x_i    (c_x[CORDIC_STEPS]),
    .y_i    (c_y[CORDIC_STEPS]),
    .rate_i (c_rate[CORDIC_STEPS]),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .lf_o   (fl),
    .rf_o   (fr),
    .lr_o   (bl),
    .rr_o   (br)
  );

  // residual angle of the last cell is not needed
  logic z_unused;
  assign z_unused = ^c_z[CORDIC_STEPS];

  assign m_axis_tdata = OUT_W'({br, bl, fr, fl});

endmodule

`default_nettype wire

// ----- sim/omni_x_drive_wheel_speeds_checker.sv -----
// Checker for the omni X drive wheel speed unit: watches both stream channels,
// predicts the four wheel speeds of every accepted request and compares results.
// Depends on oxd_pkg for the quadrant codes.
`timescale 1ns / 1ps

module omni_x_drive_wheel_speeds_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // velocity_x, velocity_y, rotation_rate, heading_offset
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // wheel speeds front-left, front-right, back-left, back-right
  input  logic [71:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);
  import oxd_pkg::QUAD_0;
  import oxd_pkg::QUAD_90;
  import oxd_pkg::QUAD_180;
  import oxd_pkg::QUAD_270;

  localparam int     ROT_STEPS = 24;
  localparam longint ROT_GAIN  = 652032874;  // Q30
  localparam logic [15:0] EIGHTH_TURN = 16'h2000;

  // arctan(2^-i), 2^32 per turn
  localparam longint ARCTAN_TURN [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // first member lands in the top bits, so list from the back-right wheel down
  typedef struct packed {
    logic [17:0] wheel_rr;
    logic [17:0] wheel_lr;
    logic [17:0] wheel_rf;
    logic [17:0] wheel_lf;
  } wheel_speeds_t;

  wheel_speeds_t expected_speeds [$];
  int error_count   = 0;
  int pending_count = 0;
  int result_count  = 0;

  assign errors_o  = error_count;
  assign pending_o = pending_count;

  function automatic wheel_speeds_t predict_wheel_speeds(logic [63:0] request);
    longint vel_x, vel_y, spin, xs, ys, z, t, dx, dy, r0, r1;
    logic [15:0] theta, qsum, resid;
    logic [1:0] quad;
    wheel_speeds_t speeds;
    vel_x = longint'($signed(request[15:0]));
    vel_y = longint'($signed(request[31:16]));
    spin  = longint'($signed(request[47:32]));
    // rotate by pi/4 - heading; strip the nearest quadrant exactly
    theta = EIGHTH_TURN - request[63:48];
    qsum  = theta + EIGHTH_TURN;
    quad  = qsum[15:14];
    resid = theta - {quad, 14'b0};
    z  = longint'($signed(resid)) * 65536;
    xs = (vel_x * ROT_GAIN) >>> 14;
    ys = (vel_y * ROT_GAIN) >>> 14;
    case (quad)
      QUAD_90: begin
        t = xs; xs = -ys; ys = t;
      end
      QUAD_180: begin
        xs = -xs; ys = -ys;
      end
      QUAD_270: begin
        t = xs; xs = ys; ys = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (z >= 0) begin
        xs -= dx; ys += dy; z -= ARCTAN_TURN[i];
      end else begin
        xs += dx; ys -= dy; z += ARCTAN_TURN[i];
      end
    end
    r0 = (xs + 32768) >>> 16;
    r1 = (ys + 32768) >>> 16;
    speeds.wheel_lf = 18'(r0 + spin);
    speeds.wheel_rf = 18'(spin - r1);
    speeds.wheel_lr = 18'(r1 + spin);
    speeds.wheel_rr = 18'(spin - r0);
    return speeds;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_wheel(string wheel, logic [17:0] got, logic [17:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             result_count, wheel, $signed(got), $signed(want)));
  endtask

  always @(posedge clk_i) begin
    wheel_speeds_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_speeds.size() == 0) begin
          report_error($sformatf("result %0d arrived with no request pending", result_count));
        end else begin
          got  = m_axis_tdata;
          want = expected_speeds.pop_front();
          check_wheel("left front",  got.wheel_lf, want.wheel_lf);
          check_wheel("right front", got.wheel_rf, want.wheel_rf);
          check_wheel("left rear",   got.wheel_lr, want.wheel_lr);
          check_wheel("right rear",  got.wheel_rr, want.wheel_rr);
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_speeds.push_back(predict_wheel_speeds(s_axis_tdata));
      pending_count <= expected_speeds.size();
    end
  end

endmodule

// ----- sim/omni_x_drive_wheel_speeds_unit_tb.sv -----
// Top of the omni X drive wheel speed testbench: clock, reset, bursty request
// stimulus, a stalling result sink and the verdict.
// Depends on omni_x_drive_wheel_speeds_unit and omni_x_drive_wheel_speeds_checker.
`timescale 1ns / 1ps

module omni_x_drive_wheel_speeds_unit_tb;

  localparam int VELOCITY_BITS = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int RANDOM_ITEMS  = 1400;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_BLOCKED
  } sink_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // velocity_x, velocity_y, rotation_rate, heading_offset
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // wheel speeds front-left, front-right, back-left, back-right
  logic [71:0] m_axis_tdata;

  int         errors;
  int         pending;
  int         burst_left = 0;
  sink_mode_e sink_mode;
  int         sink_span;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  omni_x_drive_wheel_speeds_unit #(
    .VELOCITY_BITS(VELOCITY_BITS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  omni_x_drive_wheel_speeds_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Present one command; open a gap, possibly empty, first when the current burst is used up.
  task automatic send_command(logic [15:0] vel_x, logic [15:0] vel_y,
                              logic [15:0] spin, logic [15:0] heading);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {heading, spin, vel_y, vel_x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  function automatic logic [15:0] pick_velocity();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 255)) ^ {16{$urandom_range(0, 1) == 1}};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    // hit quadrant and octant boundaries now and then
    if ($urandom_range(0, 4) == 0)
      return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
    return 16'($urandom_range(0, 65535));
  endfunction

  // Result sink: stall on its own schedule of open, random and blocked spans.
  initial begin
    forever begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_span = (sink_mode == SINK_BLOCKED) ? $urandom_range(5, 30)
                                              : $urandom_range(20, 200);
      repeat (sink_span) begin
        @(posedge clk_i);
        case (sink_mode)
          SINK_OPEN:   m_axis_tready <= 1'b1;
          SINK_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, every quadrant, octant edges and the wrap of the heading
    send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h7fff, 16'h0000, 16'h0000, 16'h2000);
    send_command(16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_command(16'h7fff, 16'h7fff, 16'h7fff, 16'he000);
    send_command(16'h8000, 16'h7fff, 16'h7fff, 16'ha000);
    send_command(16'h7fff, 16'h8000, 16'h8000, 16'h6000);
    send_command(16'h8000, 16'h8000, 16'h7fff, 16'hffff);
    send_command(16'h7fff, 16'h7fff, 16'h8000, 16'h4000);
    send_command(16'h1000, 16'h0000, 16'h0000, 16'h3fff);
    send_command(16'h1000, 16'h0000, 16'h0000, 16'h4001);
    send_command(16'h0000, 16'h1000, 16'h0000, 16'h1fff);
    send_command(16'h0000, 16'h1000, 16'h0000, 16'h2001);
    send_command(16'h0001, 16'hffff, 16'h0000, 16'h0001);
    send_command(16'hffff, 16'hffff, 16'h0000, 16'h1234);
    send_command(16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_command(16'h0000, 16'h0000, 16'h7fff, 16'hc000);
    send_command(16'h0000, 16'h0000, 16'h8000, 16'h5555);
    send_command(16'h8000, 16'h0000, 16'h0001, 16'h8001);
    send_command(16'h0000, 16'h7fff, 16'hffff, 16'h7fff);
    send_command(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_command(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

    repeat (RANDOM_ITEMS)
      send_command(pick_velocity(), pick_velocity(), pick_velocity(), pick_heading());
    s_axis_tvalid <= 1'b0;

    // let the checker's pending count take in the last request first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // let anything stray drain out of the 27-stage pipe
    repeat (60) @(posedge clk_i);
    if (errors == 0)
      $display("omni_x_drive_wheel_speeds_unit_tb passed");
    else
      $display("omni_x_drive_wheel_speeds_unit_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("omni_x_drive_wheel_speeds_unit_tb failed");
    $finish;
  end

endmodule
